FILE: sv/twer_pkg.sv
// Shared types and constants for the three-way echo ranger.
// Used by the controller, datapath, divider and top level; no dependencies.

package twer_pkg;

    localparam int TIMER_WIDTH_DEFAULT = 16;
    localparam int CAPTURE_WIDTH       = 16;
    localparam int DIVISOR_WIDTH       = 9;
    localparam int SUM_WIDTH           = 12;
    localparam int COUNT_WIDTH         = 5;
    localparam int DIST_WIDTH          = 8;
    localparam int LIMIT_WIDTH         = 8;
    localparam int SENSOR_WIDTH        = 2;
    localparam int CFG_INDEX_WIDTH     = 2;
    localparam int CFG_DATA_WIDTH      = 8;

    localparam logic [DIVISOR_WIDTH-1:0] CM_DIVISOR  = DIVISOR_WIDTH'(377);
    localparam logic [COUNT_WIDTH-1:0]   MAX_SAMPLES = COUNT_WIDTH'(16);
    localparam logic [COUNT_WIDTH-1:0]   MIN_SAMPLES = COUNT_WIDTH'(1);
    localparam logic [DIST_WIDTH-1:0]    DIST_MAX    = '1;

    // divide by the cm divisor as a multiply by its rounded-up reciprocal and a shift
    localparam int CM_RECIP_SHIFT = 24;
    localparam int CM_RECIP       = ((1 << CM_RECIP_SHIFT) + int'(CM_DIVISOR) - 1)
                                    / int'(CM_DIVISOR);
    localparam int CM_SAT_PULSE   = (int'(DIST_MAX) + 1) * int'(CM_DIVISOR);
    localparam int SCALE_WIDTH    = CM_RECIP_SHIFT + DIST_WIDTH;

    localparam logic [LIMIT_WIDTH-1:0] FRONT_LIMIT_RESET = LIMIT_WIDTH'(14);
    localparam logic [LIMIT_WIDTH-1:0] SIDE_LIMIT_RESET  = LIMIT_WIDTH'(7);
    localparam logic [COUNT_WIDTH-1:0] SAMPLES_RESET     = COUNT_WIDTH'(1);

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FRONT_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIDE_LIMIT  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SAMPLES     = 2'd2;

    localparam logic [SENSOR_WIDTH-1:0] SENSOR_LEFT   = 2'd0;
    localparam logic [SENSOR_WIDTH-1:0] SENSOR_MIDDLE = 2'd1;
    localparam logic [SENSOR_WIDTH-1:0] SENSOR_RIGHT  = 2'd2;

    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_CHECK   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ACCUM,
        ST_AVG_DIV
    } state_t;

    typedef struct packed {
        logic latch_rise;
        logic start_cm;
        logic accum;
        logic start_avg;
        logic store_reading;
        logic check;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic reading_complete;
    } dp_status_t;

endpackage

FILE: sv/twer_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on twer_pkg for the divisor width.

module twer_div #(
    parameter int DIVIDEND_WIDTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [DIVIDEND_WIDTH-1:0]          dividend,
    input  logic [twer_pkg::DIVISOR_WIDTH-1:0] divisor,
    output logic                               done,
    output logic [DIVIDEND_WIDTH-1:0]          quotient
);
    import twer_pkg::*;

    localparam int CntWidth = $clog2(DIVIDEND_WIDTH + 1);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CntWidth-1:0]       cnt_reg, cnt_next;
    logic [DIVISOR_WIDTH-1:0]  rem_reg, rem_next;
    logic [DIVISOR_WIDTH-1:0]  dsr_reg, dsr_next;
    logic [DIVIDEND_WIDTH-1:0] quo_reg, quo_next;

    logic [DIVISOR_WIDTH:0]    trial;
    logic [DIVISOR_WIDTH:0]    diff;
    logic                      fits;

    always_comb begin
        trial = {rem_reg, quo_reg[DIVIDEND_WIDTH-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = trial >= {1'b0, dsr_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CntWidth'(DIVIDEND_WIDTH);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
            quo_next = {quo_reg[DIVIDEND_WIDTH-2:0], fits};
            cnt_next = cnt_reg - CntWidth'(1);
            if (cnt_reg == CntWidth'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/twer_ctrl.sv
// Sequencing state machine and output-valid tracking for the echo ranger.
// Depends on twer_pkg for the state, command and status types.

module twer_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic                  s_rising,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  twer_pkg::dp_status_t  status,
    output twer_pkg::dp_cmd_t     cmd
);
    import twer_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_kind == KIND_CAPTURE && !s_rising) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                state_next = status.reading_complete ? ST_AVG_DIV : ST_IDLE;
            end
            ST_AVG_DIV: begin
                if (status.div_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.check      = accept && s_kind == KIND_CHECK;
                cmd.latch_rise = accept && s_kind == KIND_CAPTURE && s_rising;
                cmd.start_cm   = accept && s_kind == KIND_CAPTURE && !s_rising;
            end
            ST_SCALE: begin
                cmd.accum = 1'b1;
            end
            ST_ACCUM: begin
                cmd.start_avg = status.reading_complete;
            end
            ST_AVG_DIV: begin
                cmd.store_reading = status.div_done;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.check || cmd.store_reading) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/twer_dp.sv
// Datapath: configuration, capture state, averaging, distance store, alerts.
// Depends on twer_pkg and the twer_div divider.

module twer_dp #(
    parameter int TIMER_WIDTH = twer_pkg::TIMER_WIDTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  twer_pkg::dp_cmd_t                    cmd,
    output twer_pkg::dp_status_t                 status,
    input  logic                                 cfg_write,
    input  logic [twer_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [twer_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic [twer_pkg::CAPTURE_WIDTH-1:0]   s_capture_time,
    output logic                                 m_result_kind,
    output logic [twer_pkg::SENSOR_WIDTH-1:0]    m_sensor_id,
    output logic [twer_pkg::DIST_WIDTH-1:0]      m_distance_cm,
    output logic                                 m_announce_left,
    output logic                                 m_announce_middle,
    output logic                                 m_announce_right
);
    import twer_pkg::*;

    logic [LIMIT_WIDTH-1:0]  front_limit_reg, front_limit_next;
    logic [LIMIT_WIDTH-1:0]  side_limit_reg, side_limit_next;
    logic [COUNT_WIDTH-1:0]  samples_reg, samples_next;
    logic [SENSOR_WIDTH-1:0] active_reg, active_next;
    logic [TIMER_WIDTH-1:0]  rise_reg, rise_next;
    logic [SUM_WIDTH-1:0]    sum_reg, sum_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [DIST_WIDTH-1:0]   left_reg, left_next;
    logic [DIST_WIDTH-1:0]   middle_reg, middle_next;
    logic [DIST_WIDTH-1:0]   right_reg, right_next;
    logic [2:0]              flags_reg, flags_next;

    logic [TIMER_WIDTH-1:0]  pulse_reg, pulse_next;
    logic                    kind_reg, kind_next;
    logic [SENSOR_WIDTH-1:0] id_reg, id_next;
    logic [DIST_WIDTH-1:0]   dist_reg, dist_next;
    logic [2:0]              ann_reg, ann_next;

    logic [TIMER_WIDTH-1:0]   cap_time;
    logic [TIMER_WIDTH-1:0]   pulse_width;
    logic [SCALE_WIDTH-1:0]   pulse_ext;
    logic [SCALE_WIDTH-1:0]   cm_product;
    logic                     div_done;
    logic [SUM_WIDTH-1:0]     div_quotient;
    logic [DIST_WIDTH-1:0]    sample_cm;
    logic [COUNT_WIDTH-1:0]   target;
    logic                     near_left, near_middle, near_right;

    assign cap_time    = TIMER_WIDTH'(s_capture_time);
    assign pulse_width = cap_time - rise_reg;

    assign pulse_ext  = SCALE_WIDTH'(pulse_reg);
    assign cm_product = pulse_ext * SCALE_WIDTH'(CM_RECIP);
    assign sample_cm  = (pulse_ext >= SCALE_WIDTH'(CM_SAT_PULSE))
                        ? DIST_MAX : cm_product[SCALE_WIDTH-1:CM_RECIP_SHIFT];

    twer_div #(
        .DIVIDEND_WIDTH (SUM_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_avg),
        .dividend (sum_reg),
        .divisor  (DIVISOR_WIDTH'(count_reg)),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        if (samples_reg == '0) begin
            target = MIN_SAMPLES;
        end else if (samples_reg > MAX_SAMPLES) begin
            target = MAX_SAMPLES;
        end else begin
            target = samples_reg;
        end
    end

    always_comb begin
        status.div_done         = div_done;
        status.reading_complete = (count_reg != '0) && (count_reg >= target);
    end

    always_comb begin
        near_left   = left_reg < right_reg && left_reg < middle_reg &&
                      left_reg <= side_limit_reg && left_reg != '0;
        near_right  = right_reg < left_reg && right_reg < middle_reg &&
                      right_reg <= side_limit_reg && right_reg != '0;
        near_middle = middle_reg < left_reg && middle_reg < right_reg &&
                      middle_reg <= front_limit_reg && middle_reg != '0;
    end

    always_comb begin
        front_limit_next = front_limit_reg;
        side_limit_next  = side_limit_reg;
        samples_next     = samples_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                CFG_FRONT_LIMIT: front_limit_next = cfg_data[LIMIT_WIDTH-1:0];
                CFG_SIDE_LIMIT:  side_limit_next  = cfg_data[LIMIT_WIDTH-1:0];
                CFG_SAMPLES:     samples_next     = cfg_data[COUNT_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        active_next = active_reg;
        rise_next   = rise_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        middle_next = middle_reg;
        right_next  = right_reg;
        flags_next  = flags_reg;
        pulse_next  = pulse_reg;
        kind_next   = kind_reg;
        id_next     = id_reg;
        dist_next   = dist_reg;
        ann_next    = ann_reg;
        if (cmd.latch_rise) begin
            rise_next = cap_time;
        end
        if (cmd.start_cm) begin
            pulse_next = pulse_width;
        end
        if (cmd.accum) begin
            sum_next   = sum_reg + SUM_WIDTH'(sample_cm);
            count_next = count_reg + COUNT_WIDTH'(1);
        end
        if (cmd.store_reading) begin
            sum_next   = '0;
            count_next = '0;
            kind_next  = KIND_CAPTURE;
            id_next    = active_reg;
            dist_next  = div_quotient[DIST_WIDTH-1:0];
            ann_next   = '0;
            unique case (active_reg)
                SENSOR_LEFT: begin
                    left_next   = div_quotient[DIST_WIDTH-1:0];
                    active_next = SENSOR_MIDDLE;
                end
                SENSOR_MIDDLE: begin
                    middle_next = div_quotient[DIST_WIDTH-1:0];
                    active_next = SENSOR_RIGHT;
                end
                SENSOR_RIGHT: begin
                    right_next  = div_quotient[DIST_WIDTH-1:0];
                    active_next = SENSOR_LEFT;
                end
                default: begin
                    active_next = SENSOR_LEFT;
                end
            endcase
        end
        if (cmd.check) begin
            flags_next = flags_reg ^ {near_right, near_middle, near_left};
            kind_next  = KIND_CHECK;
            id_next    = '0;
            dist_next  = '0;
            ann_next   = {near_right, near_middle, near_left} & ~flags_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_limit_reg <= FRONT_LIMIT_RESET;
            side_limit_reg  <= SIDE_LIMIT_RESET;
            samples_reg     <= SAMPLES_RESET;
            active_reg      <= SENSOR_LEFT;
            rise_reg        <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            left_reg        <= '0;
            middle_reg      <= '0;
            right_reg       <= '0;
            flags_reg       <= '0;
        end else begin
            front_limit_reg <= front_limit_next;
            side_limit_reg  <= side_limit_next;
            samples_reg     <= samples_next;
            active_reg      <= active_next;
            rise_reg        <= rise_next;
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            left_reg        <= left_next;
            middle_reg      <= middle_next;
            right_reg       <= right_next;
            flags_reg       <= flags_next;
        end
        pulse_reg <= pulse_next;
        kind_reg  <= kind_next;
        id_reg    <= id_next;
        dist_reg  <= dist_next;
        ann_reg   <= ann_next;
    end

    assign m_result_kind     = kind_reg;
    assign m_sensor_id       = id_reg;
    assign m_distance_cm     = dist_reg;
    assign m_announce_left   = ann_reg[0];
    assign m_announce_middle = ann_reg[1];
    assign m_announce_right  = ann_reg[2];

endmodule

FILE: sv/three_way_echo_ranger_with_alerts.sv
// Timing: rising edges and check requests are taken while idle; a check answer is valid the next cycle.
// A falling edge holds the input through ST_SCALE and ST_ACCUM (latch the pulse, then scale and
// accumulate); when it completes a reading, a 12-bit averaging divide follows before the result.
// Throughput: one beat at a time; a result beat not taken (m_ready low) holds off the input.
// Reset: synchronous active-low aresetn clears state, distances, alert flags, config to defaults.
// Depends on twer_pkg, twer_ctrl, twer_dp and twer_div.

module three_way_echo_ranger_with_alerts #(
    parameter int TIMER_WIDTH = twer_pkg::TIMER_WIDTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic                                 s_rising,
    input  logic [twer_pkg::CAPTURE_WIDTH-1:0]   s_capture_time,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_result_kind,
    output logic [twer_pkg::SENSOR_WIDTH-1:0]    m_sensor_id,
    output logic [twer_pkg::DIST_WIDTH-1:0]      m_distance_cm,
    output logic                                 m_announce_left,
    output logic                                 m_announce_middle,
    output logic                                 m_announce_right,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [twer_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [twer_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import twer_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    twer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_kind   (s_kind),
        .s_rising (s_rising),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    twer_dp #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_capture_time    (s_capture_time),
        .m_result_kind     (m_result_kind),
        .m_sensor_id       (m_sensor_id),
        .m_distance_cm     (m_distance_cm),
        .m_announce_left   (m_announce_left),
        .m_announce_middle (m_announce_middle),
        .m_announce_right  (m_announce_right)
    );

    a_store_into_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_reading |-> !m_valid)
        else $error("reading stored while output beat pending");

    a_busy_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> !s_ready)
        else $error("input ready while divider finishing");

    a_check_answers: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == KIND_CHECK) |=> (m_valid && m_result_kind == KIND_CHECK))
        else $error("check request produced no answer beat");

    a_fall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_cm |=> !s_ready)
        else $error("input ready right after falling edge");

endmodule

FILE: verif/twer_echo_checker.sv
// Checker for the three-way echo ranger: follows the capture, result and register channels,
// predicts every result beat and compares it field by field with the block's output.
// Depends on twer_pkg only.

module twer_echo_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic                                 s_rising,
    input  logic [twer_pkg::CAPTURE_WIDTH-1:0]   s_capture_time,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic                                 m_result_kind,
    input  logic [twer_pkg::SENSOR_WIDTH-1:0]    m_sensor_id,
    input  logic [twer_pkg::DIST_WIDTH-1:0]      m_distance_cm,
    input  logic                                 m_announce_left,
    input  logic                                 m_announce_middle,
    input  logic                                 m_announce_right,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [twer_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [twer_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                                   fail_count,
    output int                                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import twer_pkg::*;

    typedef struct packed {
        logic                    result_kind;
        logic [SENSOR_WIDTH-1:0] sensor_id;
        logic [DIST_WIDTH-1:0]   distance_cm;
        logic                    announce_left;
        logic                    announce_middle;
        logic                    announce_right;
    } echo_result_t;

    logic [LIMIT_WIDTH-1:0]   front_lim;
    logic [LIMIT_WIDTH-1:0]   side_lim;
    logic [COUNT_WIDTH-1:0]   samples_reg;
    logic [SENSOR_WIDTH-1:0]  cur_sensor;
    logic [CAPTURE_WIDTH-1:0] rise_stamp;
    logic [SUM_WIDTH-1:0]     cm_sum;
    logic [COUNT_WIDTH-1:0]   cm_count;
    logic [DIST_WIDTH-1:0]    dist_left;
    logic [DIST_WIDTH-1:0]    dist_mid;
    logic [DIST_WIDTH-1:0]    dist_right;
    logic [2:0]               alert_flags;
    echo_result_t             due_results[$];
    int                       errors = 0;

    assign fail_count = errors;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns: %s", $time, msg);
    endtask

    function automatic logic flip_alert(input logic hit, input int idx);
        if (!hit) return 1'b0;
        alert_flags[idx] = ~alert_flags[idx];
        return alert_flags[idx];
    endfunction

    task automatic predict_beat(input logic kind, input logic rising,
                                input logic [CAPTURE_WIDTH-1:0] stamp);
        echo_result_t             res;
        logic [CAPTURE_WIDTH-1:0] pulse;
        logic [CAPTURE_WIDTH-1:0] sample;
        logic [COUNT_WIDTH-1:0]   goal;
        logic                     near_l;
        logic                     near_m;
        logic                     near_r;
        res = '0;
        if (kind == KIND_CHECK) begin
            near_l = dist_left < dist_right && dist_left < dist_mid
                     && dist_left <= side_lim && dist_left != '0;
            near_m = dist_mid < dist_left && dist_mid < dist_right
                     && dist_mid <= front_lim && dist_mid != '0;
            near_r = dist_right < dist_left && dist_right < dist_mid
                     && dist_right <= side_lim && dist_right != '0;
            res.result_kind     = KIND_CHECK;
            res.announce_left   = flip_alert(near_l, 0);
            res.announce_middle = flip_alert(near_m, 1);
            res.announce_right  = flip_alert(near_r, 2);
            due_results.push_back(res);
        end else if (rising) begin
            rise_stamp = stamp;
        end else begin
            pulse  = stamp - rise_stamp;
            sample = pulse / CAPTURE_WIDTH'(CM_DIVISOR);
            if (sample > CAPTURE_WIDTH'(DIST_MAX)) sample = CAPTURE_WIDTH'(DIST_MAX);
            cm_sum   = cm_sum + SUM_WIDTH'(sample);
            cm_count = cm_count + 1'b1;
            if (samples_reg == '0) goal = MIN_SAMPLES;
            else if (samples_reg > MAX_SAMPLES) goal = MAX_SAMPLES;
            else goal = samples_reg;
            if (cm_count != '0 && cm_count >= goal) begin
                res.result_kind = KIND_CAPTURE;
                res.sensor_id   = cur_sensor;
                res.distance_cm = DIST_WIDTH'(cm_sum / SUM_WIDTH'(cm_count));
                cm_sum   = '0;
                cm_count = '0;
                case (cur_sensor)
                    SENSOR_LEFT: begin
                        dist_left  = res.distance_cm;
                        cur_sensor = SENSOR_MIDDLE;
                    end
                    SENSOR_MIDDLE: begin
                        dist_mid   = res.distance_cm;
                        cur_sensor = SENSOR_RIGHT;
                    end
                    SENSOR_RIGHT: begin
                        dist_right = res.distance_cm;
                        cur_sensor = SENSOR_LEFT;
                    end
                    default: cur_sensor = SENSOR_LEFT;
                endcase
                due_results.push_back(res);
            end
        end
    endtask

    task automatic compare_result();
        echo_result_t want;
        if (due_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected: kind %0d sensor %0d",
                                      m_result_kind, m_sensor_id));
            return;
        end
        want = due_results.pop_front();
        if (m_result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind got %0d want %0d",
                                      m_result_kind, want.result_kind));
        if (m_sensor_id !== want.sensor_id)
            report_mismatch($sformatf("sensor_id got %0d want %0d",
                                      m_sensor_id, want.sensor_id));
        if (m_distance_cm !== want.distance_cm)
            report_mismatch($sformatf("distance_cm got %0d want %0d",
                                      m_distance_cm, want.distance_cm));
        if (m_announce_left !== want.announce_left)
            report_mismatch($sformatf("announce_left got %0d want %0d",
                                      m_announce_left, want.announce_left));
        if (m_announce_middle !== want.announce_middle)
            report_mismatch($sformatf("announce_middle got %0d want %0d",
                                      m_announce_middle, want.announce_middle));
        if (m_announce_right !== want.announce_right)
            report_mismatch($sformatf("announce_right got %0d want %0d",
                                      m_announce_right, want.announce_right));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            front_lim   = FRONT_LIMIT_RESET;
            side_lim    = SIDE_LIMIT_RESET;
            samples_reg = SAMPLES_RESET;
            cur_sensor  = SENSOR_LEFT;
            rise_stamp  = '0;
            cm_sum      = '0;
            cm_count    = '0;
            dist_left   = '0;
            dist_mid    = '0;
            dist_right  = '0;
            alert_flags = '0;
            due_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRONT_LIMIT: front_lim   = cfg_data;
                    CFG_SIDE_LIMIT:  side_lim    = cfg_data;
                    CFG_SAMPLES:     samples_reg = cfg_data[COUNT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_beat(s_kind, s_rising, s_capture_time);
            if (m_valid && m_ready) compare_result();
        end
        outstanding <= due_results.size();
    end

endmodule

FILE: verif/three_way_echo_ranger_with_alerts_tb.sv
// Top of the echo ranger testbench: clock, reset, capture and register stimulus,
// result back-pressure, watchdog and verdict. Depends on twer_pkg, the block and twer_echo_checker.

module three_way_echo_ranger_with_alerts_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import twer_pkg::*;

    localparam int ITEM_TARGET    = 1650;
    localparam int SETTLE_CYCLES  = 64;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 80;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE = 2'd3;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_kind;
    logic                       s_rising;
    logic [CAPTURE_WIDTH-1:0]   s_capture_time;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_result_kind;
    logic [SENSOR_WIDTH-1:0]    m_sensor_id;
    logic [DIST_WIDTH-1:0]      m_distance_cm;
    logic                       m_announce_left;
    logic                       m_announce_middle;
    logic                       m_announce_right;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    int fail_count;
    int outstanding;
    int items_sent;
    bit no_gaps;
    bit hold_request;

    three_way_echo_ranger_with_alerts dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_rising          (s_rising),
        .s_capture_time    (s_capture_time),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_sensor_id       (m_sensor_id),
        .m_distance_cm     (m_distance_cm),
        .m_announce_left   (m_announce_left),
        .m_announce_middle (m_announce_middle),
        .m_announce_right  (m_announce_right),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    twer_echo_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_rising          (s_rising),
        .s_capture_time    (s_capture_time),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_sensor_id       (m_sensor_id),
        .m_distance_cm     (m_distance_cm),
        .m_announce_left   (m_announce_left),
        .m_announce_middle (m_announce_middle),
        .m_announce_right  (m_announce_right),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .outstanding       (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic send_beat(input logic kind, input logic rising,
                             input logic [CAPTURE_WIDTH-1:0] stamp);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_rising       <= rising;
        s_capture_time <= stamp;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent++;
    endtask

    task automatic send_echo(input logic [CAPTURE_WIDTH-1:0] rise_at,
                             input logic [CAPTURE_WIDTH-1:0] width);
        send_beat(KIND_CAPTURE, 1'b1, rise_at);
        send_beat(KIND_CAPTURE, 1'b0, rise_at + width);
    endtask

    task automatic send_check();
        send_beat(KIND_CHECK, 1'($urandom_range(0, 1)), CAPTURE_WIDTH'($urandom));
    endtask

    // drop valid, wait for every expected beat, then let any unfinished division settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_WIDTH-1:0] front,
                                input logic [CFG_DATA_WIDTH-1:0] side,
                                input logic [CFG_DATA_WIDTH-1:0] samples,
                                input bit spare);
        logic [CFG_INDEX_WIDTH-1:0] order[4];
        logic [CFG_DATA_WIDTH-1:0]  vals[4];
        order = '{CFG_FRONT_LIMIT, CFG_SIDE_LIMIT, CFG_SAMPLES, CFG_SPARE};
        vals  = '{front, side, samples, CFG_DATA_WIDTH'($urandom)};
        for (int i = 0; i < (spare ? 4 : 3); i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int                       roll;
        int                       last;
        logic [CAPTURE_WIDTH-1:0] width;
        last = items_sent + count;
        while (items_sent < last) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 7)
                width = CAPTURE_WIDTH'($urandom_range(0, 24) * 377 + $urandom_range(0, 376));
            else
                width = CAPTURE_WIDTH'($urandom);
            if (roll < 60) send_echo(CAPTURE_WIDTH'($urandom), width);
            else if (roll < 85) send_check();
            else if (roll < 93) send_beat(KIND_CAPTURE, 1'b0, CAPTURE_WIDTH'($urandom));
            else send_beat(KIND_CAPTURE, 1'b1, CAPTURE_WIDTH'($urandom));
        end
    endtask

    initial begin : result_sink
        int gap;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 4);
            if (hold_request) begin
                gap = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        do @(posedge aclk); while (!aresetn);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int                        phase;
        logic [CFG_DATA_WIDTH-1:0] front;
        logic [CFG_DATA_WIDTH-1:0] side;
        logic [CFG_DATA_WIDTH-1:0] samples;
        s_valid        <= 1'b0;
        s_kind         <= KIND_CAPTURE;
        s_rising       <= 1'b0;
        s_capture_time <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_FRONT_LIMIT;
        cfg_data       <= '0;
        aresetn        <= 1'b0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        items_sent   = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_echo(16'h0000, 16'h0000);
        send_echo(16'h0000, 16'hFFFF);
        send_echo(16'hFFF0, 16'd2400);
        send_check();
        send_echo(16'd100, 16'd1885);
        send_check();
        send_check();
        send_echo(16'h8000, 16'd1131);
        send_check();
        send_echo(16'hFFFF, 16'd1140);
        send_check();
        wait_idle();
        program_regs(8'd0, 8'd255, 8'd0, 1'b1);
        send_echo(16'h1234, 16'd754);
        send_check();
        wait_idle();
        program_regs(8'd14, 8'd7, 8'd31, 1'b0);
        send_echo(16'h4321, 16'd5000);
        send_echo(16'hF00F, 16'd9000);
        wait_idle();
        program_regs(8'd14, 8'd7, 8'd2, 1'b0);
        send_echo(16'h0F0F, 16'd3000);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            case ($urandom_range(0, 3))
                0:       front = '0;
                1:       front = '1;
                2:       front = CFG_DATA_WIDTH'($urandom);
                default: front = CFG_DATA_WIDTH'($urandom_range(0, 30));
            endcase
            case ($urandom_range(0, 3))
                0:       side = '0;
                1:       side = '1;
                2:       side = CFG_DATA_WIDTH'($urandom);
                default: side = CFG_DATA_WIDTH'($urandom_range(0, 30));
            endcase
            case ($urandom_range(0, 7))
                0:       samples = '0;
                1:       samples = CFG_DATA_WIDTH'(MAX_SAMPLES);
                2:       samples = CFG_DATA_WIDTH'($urandom_range(17, 255));
                default: samples = CFG_DATA_WIDTH'($urandom_range(1, 4));
            endcase
            program_regs(front, side, samples, $urandom_range(0, 3) == 0);
            no_gaps = (phase % 5 == 3);
            if (phase == 2) hold_request = 1'b1;
            random_phase(PHASE_ITEMS);
            phase++;
        end

        wait_idle();
        if (fail_count == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/twer_pkg.sv
sv/twer_div.sv
sv/twer_ctrl.sv
sv/twer_dp.sv
sv/three_way_echo_ranger_with_alerts.sv
verif/twer_echo_checker.sv
verif/three_way_echo_ranger_with_alerts_tb.sv
